// File: src/smd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smd_pkg: shared types for the sliding window median filter
// Holds the control bundle that the sequencer broadcasts to every rank lane.
// ----------------------------------------------------------------------------
package smd_pkg;

    // Control broadcast from the sequencer to all rank lanes.
    typedef struct packed {
        logic clr;      // start of a new item: zero the rank counters
        logic en;       // one comparison step against the broadcast sample
        logic j_valid;  // the broadcast sample is one of the held samples
    } t_lane_ctl;

endpackage

// File: src/smd_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smd_lane: rank counter for one window entry
// Counts, over one scan of the window, how many held samples are greater
// than this entry and how many are greater than or equal to it.
// ----------------------------------------------------------------------------
module smd_lane #(
    parameter int WIDTH = 16,
    parameter int CW    = 4
) (
    input  logic                    i_clk,
    input  smd_pkg::t_lane_ctl      i_ctl,
    input  logic signed [WIDTH-1:0] i_own,
    input  logic signed [WIDTH-1:0] i_other,
    output logic [CW-1:0]           o_gt,
    output logic [CW-1:0]           o_ge
);
    import smd_pkg::*;

    logic [CW-1:0] r_gt;
    logic [CW-1:0] r_ge;
    logic [CW-1:0] n_gt;
    logic [CW-1:0] n_ge;
    logic          w_gt;
    logic          w_eq;

    assign w_gt = i_other > i_own;
    assign w_eq = i_other == i_own;

    always_comb begin
        n_gt = r_gt;
        n_ge = r_ge;
        if (i_ctl.clr) begin
            n_gt = '0;
            n_ge = '0;
        end else if (i_ctl.en && i_ctl.j_valid) begin
            if (w_gt) begin
                n_gt = r_gt + CW'(1);
            end
            if (w_gt || w_eq) begin
                n_ge = r_ge + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_gt <= n_gt;
        r_ge <= n_ge;
    end

    assign o_gt = r_gt;
    assign o_ge = r_ge;

endmodule

// File: src/smd_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smd_merge: median selection from the lane ranks
// Finds the held entries whose descending rank range covers count/2 and
// registers their value. All such entries hold the same value.
// ----------------------------------------------------------------------------
module smd_merge #(
    parameter int WINDOW = 8,
    parameter int WIDTH  = 16,
    parameter int CW     = 4
) (
    input  logic                    i_clk,
    input  logic                    i_load,
    input  logic [CW-1:0]           i_count,
    input  logic signed [WIDTH-1:0] i_vals [WINDOW],
    input  logic [CW-1:0]           i_gt   [WINDOW],
    input  logic [CW-1:0]           i_ge   [WINDOW],
    output logic signed [WIDTH-1:0] o_median
);
    import smd_pkg::*;

    logic [CW-1:0]           w_k;
    logic [WINDOW-1:0]       w_hit;
    logic [WIDTH-1:0]        w_or;
    logic signed [WIDTH-1:0] r_median;

    assign w_k = i_count >> 1;

    // Every hitting lane carries the same value, so an OR of the masked
    // values picks it without a priority encoder.
    always_comb begin
        w_or = '0;
        for (int i = 0; i < WINDOW; i++) begin
            w_hit[i] = (CW'(i) < i_count) && (i_gt[i] <= w_k) && (i_ge[i] > w_k);
            w_or     = w_or | (w_hit[i] ? i_vals[i] : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_median <= w_or;
        end
    end

    assign o_median = r_median;

endmodule

// File: src/sliding_median_2d_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_median_2d_top: two-axis sliding window median filter
// Input channel: i_valid / o_stall with i_cmd, i_pos_x, i_pos_y. A transaction
// with i_cmd = 0 stores the sample in a ring of the last WINDOW samples and
// yields one output transaction with the median of the held X samples and of
// the held Y samples (lower middle value for an even count). A transaction
// with i_cmd = 1 empties the window and yields no output.
// Output channel: o_valid / i_stall with o_median_x, o_median_y.
// One rank lane per window entry and axis compares its entry against one
// broadcast sample per cycle, so a push scans all WINDOW ring slots in turn,
// then the merge state registers both medians and the send state loads the
// output register; the next transaction is taken once the block is back in
// idle. A clear is taken in idle and leaves the block there, so it does not
// stall the input. o_stall stays high while a push is being worked on.
// When the receiver stalls, the result waits in the output register and the
// block still accepts and scans the next push; it then holds that result
// until the register frees.
// Reset empties the window and drops any pending result.
// ----------------------------------------------------------------------------
module sliding_median_2d_top #(
    parameter int WINDOW       = 8,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_cmd,
    input  logic signed [SAMPLE_WIDTH-1:0] i_pos_x,
    input  logic signed [SAMPLE_WIDTH-1:0] i_pos_y,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_median_x,
    output logic signed [SAMPLE_WIDTH-1:0] o_median_y
);
    import smd_pkg::*;

    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = $clog2(WINDOW + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_MERGE = 2'd2;
    localparam logic [1:0] S_SEND  = 2'd3;

    logic [1:0]                     r_state;
    logic [1:0]                     n_state;
    logic [IW-1:0]                  r_slot;
    logic [CW-1:0]                  r_count;
    logic [IW-1:0]                  r_j;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_x;
    logic signed [SAMPLE_WIDTH-1:0] r_out_y;

    // Entries at or beyond the held count are never selected, so the rings
    // need neither a reset value nor zeroing on a clear.
    logic signed [SAMPLE_WIDTH-1:0] r_x_ring [WINDOW];
    logic signed [SAMPLE_WIDTH-1:0] r_y_ring [WINDOW];

    logic                           w_in_acc;
    logic                           w_push;
    logic                           w_clear;
    logic                           w_out_free;
    logic                           w_last_j;
    t_lane_ctl                      w_ctl;
    logic signed [SAMPLE_WIDTH-1:0] w_x_j;
    logic signed [SAMPLE_WIDTH-1:0] w_y_j;
    logic [CW-1:0]                  w_x_gt [WINDOW];
    logic [CW-1:0]                  w_x_ge [WINDOW];
    logic [CW-1:0]                  w_y_gt [WINDOW];
    logic [CW-1:0]                  w_y_ge [WINDOW];
    logic signed [SAMPLE_WIDTH-1:0] w_med_x;
    logic signed [SAMPLE_WIDTH-1:0] w_med_y;

    assign o_stall    = (r_state != S_IDLE);
    assign w_in_acc   = i_valid && !o_stall;
    assign w_push     = w_in_acc && !i_cmd;
    assign w_clear    = w_in_acc && i_cmd;
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_last_j   = (r_j == IW'(WINDOW - 1));

    assign w_x_j = r_x_ring[r_j];
    assign w_y_j = r_y_ring[r_j];

    assign w_ctl.clr     = w_push;
    assign w_ctl.en      = (r_state == S_SCAN);
    assign w_ctl.j_valid = ({1'b0, r_j} < (IW + 1)'(r_count));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_push) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_last_j) begin
                    n_state = S_MERGE;
                end
            end
            S_MERGE: n_state = S_SEND;
            S_SEND: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_count     <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_clear) begin
                r_slot  <= '0;
                r_count <= '0;
            end else if (w_push) begin
                r_slot <= (r_slot == IW'(WINDOW - 1)) ? '0 : r_slot + IW'(1);
                if (r_count != CW'(WINDOW)) begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (w_push) begin
                r_j <= '0;
            end else if (r_state == S_SCAN && !w_last_j) begin
                r_j <= r_j + IW'(1);
            end
            if (r_state == S_SEND && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_x_ring[r_slot] <= i_pos_x;
            r_y_ring[r_slot] <= i_pos_y;
        end
        if (r_state == S_SEND && w_out_free) begin
            r_out_x <= w_med_x;
            r_out_y <= w_med_y;
        end
    end

    for (genvar g = 0; g < WINDOW; g++) begin : g_lane
        smd_lane #(
            .WIDTH (SAMPLE_WIDTH),
            .CW    (CW)
        ) u_lane_x (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_own   (r_x_ring[g]),
            .i_other (w_x_j),
            .o_gt    (w_x_gt[g]),
            .o_ge    (w_x_ge[g])
        );
        smd_lane #(
            .WIDTH (SAMPLE_WIDTH),
            .CW    (CW)
        ) u_lane_y (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_own   (r_y_ring[g]),
            .i_other (w_y_j),
            .o_gt    (w_y_gt[g]),
            .o_ge    (w_y_ge[g])
        );
    end

    smd_merge #(
        .WINDOW (WINDOW),
        .WIDTH  (SAMPLE_WIDTH),
        .CW     (CW)
    ) u_merge_x (
        .i_clk    (i_clk),
        .i_load   (r_state == S_MERGE),
        .i_count  (r_count),
        .i_vals   (r_x_ring),
        .i_gt     (w_x_gt),
        .i_ge     (w_x_ge),
        .o_median (w_med_x)
    );

    smd_merge #(
        .WINDOW (WINDOW),
        .WIDTH  (SAMPLE_WIDTH),
        .CW     (CW)
    ) u_merge_y (
        .i_clk    (i_clk),
        .i_load   (r_state == S_MERGE),
        .i_count  (r_count),
        .i_vals   (r_y_ring),
        .i_gt     (w_y_gt),
        .i_ge     (w_y_ge),
        .o_median (w_med_y)
    );

    assign o_valid    = r_out_valid;
    assign o_median_x = r_out_x;
    assign o_median_y = r_out_y;

endmodule

// File: src/smd_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smd_chk: port-level checks for the sliding window median filter
// Watches the top level's channels over time and is bound to the top level.
// ----------------------------------------------------------------------------
module smd_chk #(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    o_stall,
    input logic                    i_cmd,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic [SAMPLE_WIDTH-1:0] o_median_x
);
    import smd_pkg::*;

    // Reset leaves the block ready and with no pending result.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("block not idle after reset");

    // A push transaction always occupies the block: o_stall is high in the cycle after it.
    a_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_cmd) |=> o_stall)
        else $error("push transaction did not start a scan");

    // A clear transaction completes at once and yields no new result.
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_cmd) |=> (!o_stall && !$rose(o_valid)))
        else $error("clear transaction stalled or produced a result");

    // A stalled result stays valid and holds its X median.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_median_x)))
        else $error("stalled output transaction changed");

endmodule

bind sliding_median_2d_top smd_chk #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_smd_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .i_cmd      (i_cmd),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_median_x (o_median_x)
);
